FILE: hdl/cfhb_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfhb_pkg
// Shared types, codes and the CRC-32 byte step for the frame header builder.
// ---------------------------------------------------------------------------
package cfhb_pkg;

  // Default payload limit in bytes
  localparam int unsigned MAX_PAYLOAD_DEF = 1024;

  // Input action codes
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_CLOSE = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SID_LO = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SID_HI = 1'd1;

  // Header constants
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
  localparam logic [31:0] MAGIC_WORD   = 32'h46524453;
  localparam logic [7:0]  HDR_VERSION  = 8'h01;
  localparam logic [7:0]  TYPE_DATA    = 8'h01;
  localparam logic [7:0]  TYPE_EOF     = 8'h02;
  localparam logic [15:0] HEADER_BYTES = 16'd64;
  localparam logic [31:0] FLAG_LAST    = 32'h00000004;

  // Frame kinds
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_EOF  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic       begin_frame;  // latch begin fields, clear payload
    logic       pay_byte;     // run one payload byte
    logic       close_start;  // evaluate end of file
    logic       hcrc_init;    // preset header CRC register
    logic       hcrc_step;    // fold one header byte
    logic       hcrc_last;    // final header byte, store CRC
    logic       out_load;     // load output register
    logic [2:0] word_idx;
    logic [2:0] byte_idx;
    logic       kind;
    logic       last;
  } cfhb_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic at_end;    // frame reaches end of file
    logic out_free;  // output register can take a beat
  } cfhb_sts_t;

  // One byte through the raw (uninverted) reflected CRC-32 register
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] r;
    r = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

endpackage

FILE: hdl/cfhb_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfhb interfaces
// Input item, result and configuration write channels, valid/ready.
// ---------------------------------------------------------------------------
interface cfhb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [7:0]  data_byte;
  logic [31:0] chunk_number;
  logic [63:0] start_offset;
  logic [63:0] file_total;

  modport source (output valid, action, data_byte, chunk_number, start_offset, file_total,
                  input ready);
  modport sink   (input valid, action, data_byte, chunk_number, start_offset, file_total,
                  output ready);
endinterface

interface cfhb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] header_word;
  logic [2:0]  word_position;
  logic        frame_kind;
  logic        last;

  modport source (output valid, header_word, word_position, frame_kind, last, input ready);
  modport sink   (input valid, header_word, word_position, frame_kind, last, output ready);
endinterface

interface cfhb_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/cfhb_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfhb_dp
// Datapath: latched frame fields, payload CRC and count, header word mux,
// header CRC register and the output register.
// ---------------------------------------------------------------------------
module cfhb_dp
  import cfhb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command / status
  input  cfhb_cmd_t   cmd,
  output cfhb_sts_t   sts,
  // input payload
  input  logic [7:0]  in_data_byte,
  input  logic [31:0] in_chunk_number,
  input  logic [63:0] in_start_offset,
  input  logic [63:0] in_file_total,
  // configuration writes
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_header_word,
  output logic [2:0]  out_word_position,
  output logic        out_frame_kind,
  output logic        out_last
);

  localparam int unsigned CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

  logic [63:0]      sid_lo_r, sid_hi_r;
  logic [31:0]      chunk_r;
  logic [63:0]      offset_r, total_r;
  logic [31:0]      pay_raw_r;     // uninverted payload CRC register
  logic [CNT_W-1:0] pay_cnt_r;
  logic [31:0]      hacc_r;        // header CRC accumulator
  logic [31:0]      hcrc_r;        // finished header CRC
  logic             at_end_r;
  logic             out_valid_r;
  logic [63:0]      out_word_r;
  logic [2:0]       out_pos_r;
  logic             out_kind_r;
  logic             out_last_r;

  logic [64:0]      end_sum;
  logic             at_end_nxt;
  logic [31:0]      pay_crc;
  logic [63:0]      word_sel;
  logic [7:0]       byte_sel;
  logic [31:0]      hacc_nxt;
  logic [7:0]       f_type;
  logic [31:0]      f_chunk, f_len, f_pcrc, f_flags, f_hcrc;
  logic [63:0]      f_offset;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sid_lo_r <= '0;
      sid_hi_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SID_LO: sid_lo_r <= cfg_data;
        REG_SID_HI: sid_hi_r <= cfg_data;
        default:    sid_lo_r <= sid_lo_r;
      endcase
    end
  end

  // latched frame fields and payload accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r   <= '0;
      offset_r  <= '0;
      total_r   <= '0;
      pay_raw_r <= CRC_INIT;
      pay_cnt_r <= '0;
    end else if (cmd.begin_frame) begin
      chunk_r   <= in_chunk_number;
      offset_r  <= in_start_offset;
      total_r   <= in_file_total;
      pay_raw_r <= CRC_INIT;
      pay_cnt_r <= '0;
    end else if (cmd.pay_byte && (pay_cnt_r < MAX_CNT)) begin
      pay_raw_r <= crc_byte(pay_raw_r, in_data_byte);
      pay_cnt_r <= pay_cnt_r + 1'b1;
    end
  end

  // end of file: carry out of the sum counts as reaching the total
  assign end_sum    = {1'b0, offset_r} + {{(65 - CNT_W){1'b0}}, pay_cnt_r};
  assign at_end_nxt = end_sum[64] || (end_sum[63:0] >= total_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_end_r <= 1'b0;
    end else if (cmd.close_start) begin
      at_end_r <= at_end_nxt;
    end
  end

  // header fields for the frame kind in progress
  assign pay_crc  = (pay_cnt_r != '0) ? ~pay_raw_r : 32'd0;
  assign f_type   = (cmd.kind == KIND_EOF) ? TYPE_EOF : TYPE_DATA;
  assign f_chunk  = (cmd.kind == KIND_EOF) ? chunk_r + 32'd1 : chunk_r;
  assign f_offset = (cmd.kind == KIND_EOF) ? total_r : offset_r;
  assign f_len    = (cmd.kind == KIND_EOF) ? 32'd0 : 32'(pay_cnt_r);
  assign f_pcrc   = (cmd.kind == KIND_EOF) ? 32'd0 : pay_crc;
  assign f_flags  = ((cmd.kind == KIND_DATA) && at_end_r) ? FLAG_LAST : 32'd0;
  // CRC field reads as zero while the header CRC is computed
  assign f_hcrc   = cmd.out_load ? hcrc_r : 32'd0;

  // header word mux
  always_comb begin
    case (cmd.word_idx)
      3'd0:    word_sel = {HEADER_BYTES, f_type, HDR_VERSION, MAGIC_WORD};
      3'd1:    word_sel = sid_lo_r;
      3'd2:    word_sel = sid_hi_r;
      3'd3:    word_sel = {f_offset[31:0], f_chunk};
      3'd4:    word_sel = {f_len, f_offset[63:32]};
      3'd5:    word_sel = total_r;
      3'd6:    word_sel = {f_pcrc, f_hcrc};
      3'd7:    word_sel = {32'd0, f_flags};
      default: word_sel = '0;
    endcase
  end

  assign byte_sel = 8'(word_sel >> {cmd.byte_idx, 3'b000});
  assign hacc_nxt = crc_byte(hacc_r, byte_sel);

  // header CRC, one byte per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hacc_r <= CRC_INIT;
      hcrc_r <= '0;
    end else if (cmd.hcrc_init) begin
      hacc_r <= CRC_INIT;
    end else if (cmd.hcrc_step) begin
      hacc_r <= hacc_nxt;
      if (cmd.hcrc_last) begin
        hcrc_r <= ~hacc_nxt;
      end
    end
  end

  // output register
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.at_end   = at_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word_r <= word_sel;
      out_pos_r  <= cmd.word_idx;
      out_kind_r <= cmd.kind;
      out_last_r <= cmd.last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_header_word   = out_word_r;
  assign out_word_position = out_pos_r;
  assign out_frame_kind    = out_kind_r;
  assign out_last          = out_last_r;

endmodule

FILE: hdl/cfhb_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfhb_ctrl
// Controller: decodes input items, sequences the header CRC pass and the
// eight-beat emission of each header.
// ---------------------------------------------------------------------------
module cfhb_ctrl
  import cfhb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  output cfhb_cmd_t  cmd,
  input  cfhb_sts_t  sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       kind_r, kind_nxt;
  logic       in_fire;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    kind_nxt  = kind_r;
    cmd       = '0;
    cmd.kind  = kind_r;
    cmd.word_idx = (state_r == S_CRC) ? cnt_r[5:3] : cnt_r[2:0];
    cmd.byte_idx = cnt_r[2:0];
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_action)
            ACT_BEGIN: cmd.begin_frame = 1'b1;
            ACT_BYTE:  cmd.pay_byte = 1'b1;
            ACT_CLOSE: begin
              cmd.close_start = 1'b1;
              cmd.hcrc_init   = 1'b1;
              kind_nxt        = KIND_DATA;
              cnt_nxt         = '0;
              state_nxt       = S_CRC;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CRC: begin
        cmd.hcrc_step = 1'b1;
        cmd.hcrc_last = (cnt_r == 6'd63);
        cnt_nxt       = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.last = (cnt_r[2:0] == 3'd7) && (kind_r == KIND_EOF || !sts.at_end);
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cnt_nxt      = cnt_r + 6'd1;
          if (cnt_r[2:0] == 3'd7) begin
            cnt_nxt = '0;
            if (kind_r == KIND_DATA && sts.at_end) begin
              kind_nxt      = KIND_EOF;
              cmd.hcrc_init = 1'b1;
              state_nxt     = S_CRC;
            end else begin
              kind_nxt  = KIND_DATA;
              state_nxt = S_IDLE;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      kind_r  <= KIND_DATA;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      kind_r  <= kind_nxt;
    end
  end

  // the final beat of a run always returns to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && cmd.last) |=> (state_r == S_IDLE))
    else $error("last beat did not end the run");

  // CRC pass covers exactly 64 bytes before emission
  a_crc_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CRC && cnt_r == 6'd63) |=> (state_r == S_EMIT && cnt_r == 6'd0))
    else $error("header CRC pass length wrong");

  // an EOF header is only built for a frame that ends the file
  a_eof_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (kind_r == KIND_EOF) |-> sts.at_end)
    else $error("EOF header without end of file");

  // emission starts at word zero
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(state_r == S_EMIT)) |-> (cnt_r == 6'd0))
    else $error("emission did not start at word zero");

endmodule

FILE: hdl/chunk_frame_header_builder_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chunk_frame_header_builder_core
// Builds the CRC-32 protected 64-byte data-frame header, and the EOF header
// that follows when the frame ends the file, as 64-bit beats.
//
//   channel  | dir | payload
//   ---------+-----+------------------------------------------------------
//   in_bus   | in  | action, data_byte, chunk_number, start_offset, file_total
//   out_bus  | out | header_word, word_position, frame_kind, last
//   cfg_bus  | in  | index (0 session id low, 1 session id high), data
//
// Begin, payload byte and unused actions are taken in the idle state.
// A close runs a header CRC pass over 64 bytes (one byte per cycle through
// the CRC unit) plus 8 output beats; an end-of-file close repeats this for the
// EOF header. Input is held off during a close.
// Reset (rst_n low, synchronous) clears latched fields, payload and session id.
// out_bus.ready low stalls emission; the last beat waits in the output
// register while the next item is taken.
// ---------------------------------------------------------------------------
module chunk_frame_header_builder_core
  import cfhb_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  cfhb_in_if.sink       in_bus,
  cfhb_out_if.source    out_bus,
  cfhb_cfg_if.sink      cfg_bus
);

  cfhb_cmd_t cmd;
  cfhb_sts_t sts;

  // configuration writes are always taken
  assign cfg_bus.ready = 1'b1;

  // controller
  cfhb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .in_action (in_bus.action),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath
  cfhb_dp #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_data_byte      (in_bus.data_byte),
    .in_chunk_number   (in_bus.chunk_number),
    .in_start_offset   (in_bus.start_offset),
    .in_file_total     (in_bus.file_total),
    .cfg_valid         (cfg_bus.valid),
    .cfg_index         (cfg_bus.index),
    .cfg_data          (cfg_bus.data),
    .out_valid         (out_bus.valid),
    .out_ready         (out_bus.ready),
    .out_header_word   (out_bus.header_word),
    .out_word_position (out_bus.word_position),
    .out_frame_kind    (out_bus.frame_kind),
    .out_last          (out_bus.last)
  );

endmodule
